@@ hdl/twte_pkg.sv @@
// ----------------------------------------------------------------------------
// twte_pkg
// Shared types, constants and register codes of the timing wheel timer engine.
// ----------------------------------------------------------------------------
package twte_pkg;

   localparam int DEF_NUM_SLOTS  = 256;
   localparam int DEF_NUM_TIMERS = 32;

   localparam int KIND_W    = 2;
   localparam int ID_W      = 5;
   localparam int MS_W      = 22;
   localparam int STATUS_W  = 2;
   localparam int TICK_W    = 16;
   localparam int SIZE_W    = 9;
   localparam int MAXS_W    = 16;
   localparam int MS_PER_SEC = 1000;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_TICK_MS = 2'd0;
   localparam logic [1:0] REG_SLOTS   = 2'd1;
   localparam logic [1:0] REG_MAX_SEC = 2'd2;

   // classified word passed from front to back
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   timer_id;
      logic [MS_W-1:0]   delay_ms;
      logic              too_big;
   } cmd_type;

endpackage

@@ hdl/twte_front.sv @@
// ----------------------------------------------------------------------------
// twte_front
// Accepts items, checks the timeout limit and queues classified words.
// ----------------------------------------------------------------------------
module twte_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [twte_pkg::KIND_W-1:0]   req_kind,
   input  logic [twte_pkg::ID_W-1:0]     req_timer_id,
   input  logic [twte_pkg::MS_W-1:0]     req_delay_ms,
   input  logic [twte_pkg::MAXS_W-1:0]   max_seconds,
   output logic                          q_valid,
   output twte_pkg::cmd_type             q_word,
   input  logic                          q_pop
);

   // two-entry queue
   twte_pkg::cmd_type q_mem_ff [2];
   logic              rd_ptr_ff, wr_ptr_ff;
   logic [1:0]        cnt_ff;
   logic              push;
   twte_pkg::cmd_type word;
   logic [twte_pkg::MS_W+9:0] lim;

   // limit in ms: (max+1)*1000, timeout too large when ms >= that
   assign lim = ({10'd0, 6'd0, max_seconds} + 32'd1) * 32'(twte_pkg::MS_PER_SEC);

   always_comb begin
      word.kind     = req_kind;
      word.timer_id = req_timer_id;
      word.delay_ms = req_delay_ms;
      word.too_big  = {10'd0, req_delay_ms} >= lim;
   end

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word  = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wr_ptr_ff] <= word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule

@@ hdl/twte_back.sv @@
// ----------------------------------------------------------------------------
// twte_back
// Executes arm, cancel and tick words: serial divide, timer table, tick scan.
// ----------------------------------------------------------------------------
module twte_back #(
   parameter int NUM_SLOTS  = twte_pkg::DEF_NUM_SLOTS,
   parameter int NUM_TIMERS = twte_pkg::DEF_NUM_TIMERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  twte_pkg::cmd_type             q_word,
   output logic                          q_pop,
   input  logic [twte_pkg::TICK_W-1:0]   tick_ms,
   input  logic [twte_pkg::SIZE_W-1:0]   slots_in_use,
   output logic                          rsp_valid,
   output logic [twte_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_fired,
   output logic [twte_pkg::ID_W-1:0]     rsp_expired_id,
   output logic                          rsp_last
);

   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int TW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int NW  = $clog2(NUM_SLOTS + 1);
   localparam int MSW = twte_pkg::MS_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]  state_ff, state_in;
   twte_pkg::cmd_type cmd_ff;
   logic [MSW-1:0] quo_ff, quo_in;
   logic [twte_pkg::TICK_W:0] rem_ff, rem_in;
   logic [4:0]  step_ff, step_in;
   logic [MSW:0] red_ff, red_in;        // (count + cursor) reduced mod n, bit-serial
   logic [SW-1:0] cursor_ff, cursor_in;
   logic [TW-1:0] scan_ff, scan_in;
   logic          any_ff, any_in;
   logic [twte_pkg::ID_W-1:0] pend_id_ff, pend_id_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [SW-1:0] slot_ff [NUM_TIMERS];
   logic          slot_we;
   logic [SW-1:0] slot_wd;
   logic [TW-1:0] slot_wa;

   logic [twte_pkg::TICK_W-1:0] t_eff;
   logic [NW-1:0] n_eff;
   logic [twte_pkg::TICK_W:0] rem_sh;
   logic [MSW-1:0] cnt;
   logic [MSW:0]  ext;
   logic          hit;
   logic          id_ok;
   logic [MSW:0]  red_sh;

   // effective tick and wheel size
   always_comb begin
      t_eff = (tick_ms == '0) ? twte_pkg::TICK_W'(1) : tick_ms;
      if (slots_in_use == '0) n_eff = NW'(1);
      else if ({{(32-twte_pkg::SIZE_W){1'b0}}, slots_in_use} > NUM_SLOTS)
         n_eff = NW'(NUM_SLOTS);
      else n_eff = NW'(slots_in_use);
   end

   assign id_ok = ({{(32-twte_pkg::ID_W){1'b0}}, cmd_ff.timer_id} < NUM_TIMERS);
   assign rem_sh = {rem_ff[twte_pkg::TICK_W-1:0], quo_ff[MSW-1]};
   // ceil(ms/t)-1 floored at zero: quotient minus one if exact
   assign cnt = (rem_ff == '0) ? ((quo_ff == '0) ? '0 : quo_ff - MSW'(1)) : quo_ff;
   // slot offset plus cursor, reduced as a whole
   assign ext = {1'b0, cnt} + {{(MSW+1-SW){1'b0}}, cursor_ff};
   assign red_sh = {red_ff[MSW-1:0], ext[5'(MSW) - step_ff]};
   assign hit = armed_ff[scan_ff] && (slot_ff[scan_ff] == cursor_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      red_in    = red_ff;
      cursor_in = cursor_ff;
      scan_in   = scan_ff;
      any_in    = any_ff;
      pend_id_in = pend_id_ff;
      armed_in  = armed_ff;
      slot_we   = 1'b0;
      slot_wa   = cmd_ff.timer_id[TW-1:0];
      slot_wd   = '0;
      q_pop     = 1'b0;
      rsp_valid = 1'b0;
      rsp_status = twte_pkg::ST_OK;
      rsp_fired  = 1'b0;
      rsp_expired_id = '0;
      rsp_last   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               quo_in = q_word.delay_ms;
               rem_in = '0;
               step_in = '0;
               red_in = '0;
               scan_in = '0;
               any_in = 1'b0;
               if (q_word.kind == twte_pkg::KIND_ARM && !q_word.too_big)
                  state_in = S_DIV;
               else if (q_word.kind == twte_pkg::KIND_TICK)
                  state_in = S_SCAN;
               else
                  state_in = S_FIN;
            end
         end
         // restoring division, one quotient bit a cycle
         S_DIV: begin
            if (rem_sh >= {1'b0, t_eff}) begin
               rem_in = rem_sh - {1'b0, t_eff};
               quo_in = {quo_ff[MSW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[MSW-2:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(MSW-1)) begin
               step_in = '0;
               state_in = S_MOD;
            end
         end
         // (cnt + cursor) mod n, one bit a cycle from the top
         S_MOD: begin
            if (red_sh >= {{(MSW+1-NW){1'b0}}, n_eff})
               red_in = red_sh - {{(MSW+1-NW){1'b0}}, n_eff};
            else
               red_in = red_sh;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(MSW)) state_in = S_FIN;
         end
         // each expiry is held one hit so the final one can carry last
         S_SCAN: begin
            if (hit) begin
               armed_in[scan_ff] = 1'b0;
               any_in = 1'b1;
               pend_id_in = twte_pkg::ID_W'(scan_ff);
               if (any_ff) begin
                  rsp_valid = 1'b1;
                  rsp_fired = 1'b1;
                  rsp_expired_id = pend_id_ff;
               end
            end
            if ({{(32-TW){1'b0}}, scan_ff} == NUM_TIMERS - 1) begin
               if ({{(32-SW){1'b0}}, cursor_ff} + 1 >= {{(32-NW){1'b0}}, n_eff})
                  cursor_in = '0;
               else
                  cursor_in = cursor_ff + SW'(1);
               state_in = S_FIN;
            end else begin
               scan_in = scan_ff + TW'(1);
            end
         end
         default: begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            state_in  = S_IDLE;
            if (cmd_ff.kind == twte_pkg::KIND_ARM) begin
               if (cmd_ff.too_big) rsp_status = twte_pkg::ST_TOO_BIG;
               else if (id_ok) begin
                  slot_we = 1'b1;
                  slot_wd = red_ff[SW-1:0];
                  armed_in[slot_wa] = 1'b1;
               end
            end else if (cmd_ff.kind == twte_pkg::KIND_CANCEL) begin
               if (id_ok) armed_in[slot_wa] = 1'b0;
            end else if (cmd_ff.kind == twte_pkg::KIND_TICK) begin
               if (!any_ff) rsp_status = twte_pkg::ST_EMPTY;
               else begin
                  rsp_fired = 1'b1;
                  rsp_expired_id = pend_id_ff;
               end
            end
         end
      endcase
   end

   // hold the word being executed
   always_ff @(posedge clock) begin
      if (q_pop) cmd_ff <= q_word;
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      red_ff  <= red_in;
      scan_ff <= scan_in;
      any_ff  <= any_in;
      pend_id_ff <= pend_id_in;
      if (slot_we) slot_ff[slot_wa] <= slot_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cursor_ff <= '0;
         armed_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         armed_ff  <= armed_in;
      end
   end

endmodule

@@ hdl/timing_wheel_timer_engine_unit.sv @@
// ----------------------------------------------------------------------------
// timing_wheel_timer_engine_unit
// Single-level hashed timing wheel for a fixed set of timers.
// ----------------------------------------------------------------------------
// Items enter on start when busy is low into a two-word queue, so busy rises
// only while two words wait behind the one in progress; the back end runs one
// item at a time. An arm takes the item, runs a 22-step serial divide by
// tick_ms and a 23-step reduction of the count plus the cursor by the wheel
// size, then writes the table and answers; a rejected arm, a cancel and kind 3
// are answered straight after being taken; a tick scans one id a cycle,
// each expiry leaving with the next hit after it is found and the final one with
// the closing result. Results show for one cycle on rsp_valid and cannot be
// held off by the receiver.
module timing_wheel_timer_engine_unit #(
   parameter int NUM_SLOTS  = twte_pkg::DEF_NUM_SLOTS,
   parameter int NUM_TIMERS = twte_pkg::DEF_NUM_TIMERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [twte_pkg::KIND_W-1:0]   req_kind,
   input  logic [twte_pkg::ID_W-1:0]     req_timer_id,
   input  logic [twte_pkg::MS_W-1:0]     req_delay_ms,
   output logic                          rsp_valid,
   output logic [twte_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_fired,
   output logic [twte_pkg::ID_W-1:0]     rsp_expired_id,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [twte_pkg::TICK_W-1:0] tick_ms_ff;
   logic [twte_pkg::SIZE_W-1:0] slots_ff;
   logic [twte_pkg::MAXS_W-1:0] max_sec_ff;
   logic              q_valid, q_pop;
   twte_pkg::cmd_type q_word;
   logic              wr;

   // register file
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff <= 16'd10;
         slots_ff   <= 9'd256;
         max_sec_ff <= 16'd60;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         unique case (csr_paddr[3:2])
            twte_pkg::REG_TICK_MS: tick_ms_ff <= csr_pwdata[15:0];
            twte_pkg::REG_SLOTS:   slots_ff   <= csr_pwdata[8:0];
            twte_pkg::REG_MAX_SEC: max_sec_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         twte_pkg::REG_TICK_MS: csr_prdata = {16'd0, tick_ms_ff};
         twte_pkg::REG_SLOTS:   csr_prdata = {23'd0, slots_ff};
         twte_pkg::REG_MAX_SEC: csr_prdata = {16'd0, max_sec_ff};
         default:               csr_prdata = '0;
      endcase
   end

   twte_front u_front (
      .clock, .reset, .start, .busy,
      .req_kind, .req_timer_id, .req_delay_ms,
      .max_seconds (max_sec_ff),
      .q_valid, .q_word, .q_pop
   );

   twte_back #(.NUM_SLOTS(NUM_SLOTS), .NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock, .reset, .q_valid, .q_word, .q_pop,
      .tick_ms (tick_ms_ff), .slots_in_use (slots_ff),
      .rsp_valid, .rsp_status, .rsp_fired, .rsp_expired_id, .rsp_last
   );

endmodule
